// File: rtl/lpt_pkg.sv
`timescale 1ns / 1ps

package lpt_pkg;

    localparam int ENTRIES_DEF        = 32;
    localparam int PAGE_SIZE_LOG2_DEF = 12;

    localparam logic [5:0] MAX_UNPINNED_RESET = 6'd16;

    // request kinds
    localparam logic [2:0] KIND_GET      = 3'd0;
    localparam logic [2:0] KIND_RELEASE  = 3'd1;
    localparam logic [2:0] KIND_DIRTY    = 3'd2;
    localparam logic [2:0] KIND_FLUSH    = 3'd3;
    localparam logic [2:0] KIND_TRUNCATE = 3'd4;

    // result events
    localparam logic [1:0] EV_REPLY   = 2'd0;
    localparam logic [1:0] EV_EVICT   = 2'd1;
    localparam logic [1:0] EV_WRITE   = 2'd2;
    localparam logic [1:0] EV_DROPPED = 2'd3;

    // reply status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // operations on the entry flags
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PIN_NEW,
        OP_PIN_HIT,
        OP_UNPIN,
        OP_SET_DIRTY,
        OP_CLR_DIRTY,
        OP_DROP
    } t_op;

endpackage

// File: rtl/lpt_page_mem.sv
`timescale 1ns / 1ps

module lpt_page_mem #(
    parameter int DEPTH = lpt_pkg::ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lpt_entry_flags.sv
`timescale 1ns / 1ps

module lpt_entry_flags #(
    parameter int ENTRIES = lpt_pkg::ENTRIES_DEF,
    parameter int SW      = $clog2(ENTRIES),
    parameter int CW      = $clog2(ENTRIES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpt_pkg::t_op      i_op,
    input  logic [SW-1:0]     i_slot,
    output logic [ENTRIES-1:0] o_valid,
    output logic [ENTRIES-1:0] o_dirty,
    output logic              o_free_any,
    output logic [SW-1:0]     o_free_slot,
    output logic              o_victim_any,
    output logic [SW-1:0]     o_victim_slot,
    output logic [CW-1:0]     o_unpinned
);

    logic [ENTRIES-1:0] r_valid, r_pinned, r_dirty;
    logic [ENTRIES-1:0] n_valid, n_pinned, n_dirty;
    logic [SW-1:0]      r_rank [ENTRIES];
    logic [SW-1:0]      n_rank [ENTRIES];
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               unlink;

    always_comb begin
        n_valid  = r_valid;
        n_pinned = r_pinned;
        n_dirty  = r_dirty;
        n_rank   = r_rank;
        n_cnt    = r_cnt;
        unlink   = 1'b0;
        case (i_op)
            lpt_pkg::OP_PIN_NEW: begin
                n_valid[i_slot]  = 1'b1;
                n_pinned[i_slot] = 1'b1;
                n_dirty[i_slot]  = 1'b0;
                n_rank[i_slot]   = '0;
            end
            lpt_pkg::OP_PIN_HIT: begin
                unlink           = !r_pinned[i_slot];
                n_pinned[i_slot] = 1'b1;
            end
            lpt_pkg::OP_UNPIN: begin
                if (r_pinned[i_slot]) begin
                    n_pinned[i_slot] = 1'b0;
                    n_rank[i_slot]   = r_cnt[SW-1:0];
                    n_cnt            = r_cnt + 1'b1;
                end
            end
            lpt_pkg::OP_SET_DIRTY: n_dirty[i_slot] = 1'b1;
            lpt_pkg::OP_CLR_DIRTY: n_dirty[i_slot] = 1'b0;
            lpt_pkg::OP_DROP: begin
                unlink           = !r_pinned[i_slot];
                n_valid[i_slot]  = 1'b0;
                n_pinned[i_slot] = 1'b0;
                n_dirty[i_slot]  = 1'b0;
            end
            default: ;
        endcase
        // close the gap left in the LRU order
        if (unlink) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && !r_pinned[i] && (i != int'(i_slot))
                    && (r_rank[i] > r_rank[i_slot])) begin
                    n_rank[i] = r_rank[i] - 1'b1;
                end
            end
            if (r_cnt != '0) begin
                n_cnt = r_cnt - 1'b1;
            end
        end
        if (unlink || (i_op == lpt_pkg::OP_DROP)) begin
            n_rank[i_slot] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_pinned <= '0;
            r_dirty  <= '0;
            r_cnt    <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid  <= n_valid;
            r_pinned <= n_pinned;
            r_dirty  <= n_dirty;
            r_cnt    <= n_cnt;
            r_rank   <= n_rank;
        end
    end

    // lowest free slot and oldest unpinned entry
    always_comb begin
        o_free_any    = 1'b0;
        o_free_slot   = '0;
        o_victim_any  = 1'b0;
        o_victim_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                o_free_any  = 1'b1;
                o_free_slot = SW'(i);
            end
            if (r_valid[i] && !r_pinned[i] && (r_rank[i] == '0)) begin
                o_victim_any  = 1'b1;
                o_victim_slot = SW'(i);
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_dirty    = r_dirty;
    assign o_unpinned = r_cnt;

    a_cnt_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid & ~r_pinned) == int'(r_cnt))
        else $error("unpinned count out of step with flags");

endmodule

// File: rtl/pinned_lru_page_table.sv
`timescale 1ns / 1ps
// Get, release and mark dirty scan the page memory before the reply; release then checks the
//   limit and evicts the oldest unpinned pages while over it. Flush scans once per dirty page
//   plus one final scan; truncate reads and compares each slot in turn. Throughput: one request at
//   a time. The scan reads one slot per cycle through the page memory's one read port.
// Reset (i_rst_n low, synchronous): table empty, all flags clear, max_unpinned = 16.

module pinned_lru_page_table #(
    parameter int ENTRIES        = lpt_pkg::ENTRIES_DEF,
    parameter int PAGE_SIZE_LOG2 = lpt_pkg::PAGE_SIZE_LOG2_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,      // max_unpinned
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,   // [31:0] page_number, [71:32] file_size
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [1:0] status, [2] hit, [7:3] slot, [39:8] page_out
    output logic [1:0]  o_m_axis_tuser,   // [1:0] event_res
    output logic        o_m_axis_tlast    // last
);

    localparam int SW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(ENTRIES - 1);
    localparam logic [CW-1:0] N_ENTRIES = CW'(ENTRIES);
    localparam logic [40:0]   PAGE_MASK = (41'd1 << PAGE_SIZE_LOG2) - 41'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_EVICT_CHK,
        S_EVICT_OUT,
        S_FLUSH_OUT,
        S_TRUNC_RD,
        S_TRUNC_CMP,
        S_REPLY
    } t_state;

    t_state        r_state, n_state;
    logic [2:0]    r_kind, n_kind;
    logic [31:0]   r_key, n_key;
    logic [40:0]   r_limit, n_limit;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_cmp_vld, n_cmp_vld;
    logic [SW-1:0] r_cmp_idx, n_cmp_idx;
    logic          r_found, n_found;
    logic [SW-1:0] r_fslot, n_fslot;
    logic [31:0]   r_min, n_min;
    logic [SW-1:0] r_vslot, n_vslot;
    logic [1:0]    r_status, n_status;
    logic          r_hit, n_hit;
    logic [SW-1:0] r_slot, n_slot;
    logic [5:0]    r_max_unpinned;

    // output register
    logic          r_out_valid;
    logic [1:0]    r_out_ev, r_out_st;
    logic          r_out_hit, r_out_last;
    logic [4:0]    r_out_slot;
    logic [31:0]   r_out_page;

    logic          out_free;
    logic          emit;
    logic [1:0]    e_ev, e_st;
    logic          e_hit, e_last;
    logic [SW-1:0] e_slot;
    logic [31:0]   e_page;

    // page memory and flags
    logic          mem_we;
    logic [SW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_rdata;

    lpt_pkg::t_op       op;
    logic [SW-1:0]      op_slot;
    logic [ENTRIES-1:0] f_valid, f_dirty;
    logic               free_any, victim_any;
    logic [SW-1:0]      free_slot, victim_slot;
    logic [CW-1:0]      unpinned;
    logic               accept;
    logic               over_limit;

    lpt_page_mem #(.DEPTH(ENTRIES), .AW(SW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(r_key),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    lpt_entry_flags #(.ENTRIES(ENTRIES), .SW(SW), .CW(CW)) u_flags (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_slot       (op_slot),
        .o_valid      (f_valid),
        .o_dirty      (f_dirty),
        .o_free_any   (free_any),
        .o_free_slot  (free_slot),
        .o_victim_any (victim_any),
        .o_victim_slot(victim_slot),
        .o_unpinned   (unpinned)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign over_limit      = 7'(unpinned) > 7'(r_max_unpinned);

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_key     = r_key;
        n_limit   = r_limit;
        n_idx     = r_idx;
        n_cmp_vld = 1'b0;
        n_cmp_idx = r_cmp_idx;
        n_found   = r_found;
        n_fslot   = r_fslot;
        n_min     = r_min;
        n_vslot   = r_vslot;
        n_status  = r_status;
        n_hit     = r_hit;
        n_slot    = r_slot;
        emit      = 1'b0;
        e_ev      = lpt_pkg::EV_REPLY;
        e_st      = lpt_pkg::ST_OK;
        e_hit     = 1'b0;
        e_last    = 1'b0;
        e_slot    = '0;
        e_page    = '0;
        mem_we    = 1'b0;
        mem_waddr = free_slot;
        mem_raddr = r_idx[SW-1:0];
        op        = lpt_pkg::OP_NONE;
        op_slot   = r_fslot;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind   = i_s_axis_tuser;
                    n_key    = i_s_axis_tdata[31:0];
                    n_limit  = ({1'b0, i_s_axis_tdata[71:32]} + PAGE_MASK) >> PAGE_SIZE_LOG2;
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_status = lpt_pkg::ST_OK;
                    n_hit    = 1'b0;
                    n_slot   = '0;
                    case (i_s_axis_tuser) inside
                        lpt_pkg::KIND_GET, lpt_pkg::KIND_RELEASE,
                        lpt_pkg::KIND_DIRTY, lpt_pkg::KIND_FLUSH: n_state = S_SCAN;
                        lpt_pkg::KIND_TRUNCATE:                   n_state = S_TRUNC_RD;
                        default:                                  n_state = S_REPLY;
                    endcase
                end
            end
            S_SCAN: begin
                // issue one read a cycle, compare the data returned from the previous one
                if (r_idx < N_ENTRIES) begin
                    n_idx     = r_idx + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[SW-1:0];
                end
                if (r_cmp_vld) begin
                    if (r_kind == lpt_pkg::KIND_FLUSH) begin
                        if (f_valid[r_cmp_idx] && f_dirty[r_cmp_idx]
                            && (!r_found || (mem_rdata < r_min))) begin
                            n_found = 1'b1;
                            n_fslot = r_cmp_idx;
                            n_min   = mem_rdata;
                        end
                    end else if (!r_found && f_valid[r_cmp_idx] && (mem_rdata == r_key)) begin
                        n_found = 1'b1;
                        n_fslot = r_cmp_idx;
                    end
                    if (r_cmp_idx == LAST_SLOT) begin
                        n_cmp_vld = 1'b0;
                        n_state   = S_ACT;
                    end
                end
            end
            S_ACT: begin
                n_state = S_REPLY;
                n_slot  = r_fslot;
                case (r_kind)
                    lpt_pkg::KIND_GET: begin
                        if (r_found) begin
                            op    = lpt_pkg::OP_PIN_HIT;
                            n_hit = 1'b1;
                        end else if (free_any) begin
                            mem_we  = 1'b1;
                            op      = lpt_pkg::OP_PIN_NEW;
                            op_slot = free_slot;
                            n_slot  = free_slot;
                        end else begin
                            n_status = lpt_pkg::ST_FULL;
                            n_slot   = '0;
                        end
                    end
                    lpt_pkg::KIND_RELEASE: begin
                        if (r_found) begin
                            op      = lpt_pkg::OP_UNPIN;
                            n_state = S_EVICT_CHK;
                        end else begin
                            n_status = lpt_pkg::ST_NOT_FOUND;
                            n_slot   = '0;
                        end
                    end
                    lpt_pkg::KIND_DIRTY: begin
                        if (r_found) begin
                            op = lpt_pkg::OP_SET_DIRTY;
                        end else begin
                            n_status = lpt_pkg::ST_NOT_FOUND;
                            n_slot   = '0;
                        end
                    end
                    default: begin
                        // flush: write out the smallest dirty page, or finish
                        n_slot = '0;
                        if (r_found) begin
                            n_state = S_FLUSH_OUT;
                        end
                    end
                endcase
            end
            S_EVICT_CHK: begin
                mem_raddr = victim_slot;
                if (over_limit && victim_any) begin
                    n_vslot = victim_slot;
                    n_state = S_EVICT_OUT;
                end else begin
                    n_state = S_REPLY;
                end
            end
            S_EVICT_OUT: begin
                mem_raddr = r_vslot;
                if (out_free) begin
                    emit    = 1'b1;
                    e_ev    = lpt_pkg::EV_EVICT;
                    e_slot  = r_vslot;
                    e_page  = mem_rdata;
                    op      = lpt_pkg::OP_DROP;
                    op_slot = r_vslot;
                    n_state = S_EVICT_CHK;
                end
            end
            S_FLUSH_OUT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_ev    = lpt_pkg::EV_WRITE;
                    e_slot  = r_fslot;
                    e_page  = r_min;
                    op      = lpt_pkg::OP_CLR_DIRTY;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_TRUNC_RD: begin
                n_state = S_TRUNC_CMP;
            end
            S_TRUNC_CMP: begin
                if (f_valid[r_idx[SW-1:0]] && (41'(mem_rdata) > r_limit)) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        e_ev    = lpt_pkg::EV_DROPPED;
                        e_slot  = r_idx[SW-1:0];
                        e_page  = mem_rdata;
                        op      = lpt_pkg::OP_DROP;
                        op_slot = r_idx[SW-1:0];
                        n_state = S_TRUNC_RD;
                    end
                end else begin
                    n_state = S_TRUNC_RD;
                end
                if (n_state == S_TRUNC_RD) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx[SW-1:0] == LAST_SLOT) begin
                        n_state = S_REPLY;
                    end
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_st    = r_status;
                    e_hit   = r_hit;
                    e_slot  = r_slot;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cmp_vld      <= 1'b0;
            r_out_valid    <= 1'b0;
            r_max_unpinned <= lpt_pkg::MAX_UNPINNED_RESET;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            if (i_cfg_we) begin
                r_max_unpinned <= i_cfg_wdata;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_key     <= n_key;
        r_limit   <= n_limit;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_found   <= n_found;
        r_fslot   <= n_fslot;
        r_min     <= n_min;
        r_vslot   <= n_vslot;
        r_status  <= n_status;
        r_hit     <= n_hit;
        r_slot    <= n_slot;
        if (emit) begin
            r_out_ev   <= e_ev;
            r_out_st   <= e_st;
            r_out_hit  <= e_hit;
            r_out_last <= e_last;
            r_out_slot <= 5'(e_slot);
            r_out_page <= e_page;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_page, r_out_slot, r_out_hit, r_out_st};
    assign o_m_axis_tuser  = r_out_ev;
    assign o_m_axis_tlast  = r_out_last;

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("result register overwritten");

    a_reply_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (o_m_axis_tuser == lpt_pkg::EV_REPLY))
        else $error("last set on an event result");

    a_write_on_get_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ((r_state == S_ACT) && (r_kind == lpt_pkg::KIND_GET) && !r_found))
        else $error("page memory written outside a get miss");

endmodule
